/* src/mcr_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mcr_pkg
// Shared types, widths and constants of the midpoint circle rasterizer.
// ----------------------------------------------------------------------------
package mcr_pkg;

    // coordinate and field widths
    localparam int COORD_W   = 12;
    localparam int RAD_W     = 10;
    localparam int LOOP_W    = RAD_W + 1;
    localparam int OFF_W     = LOOP_W + 1;
    localparam int DEC_W     = 16;
    localparam int COLOUR_W  = 16;
    localparam int MODE_W    = 2;
    localparam int SLOTS     = 4;
    localparam int SLOT_W    = $clog2(SLOTS);
    localparam int SUM_W     = ((COORD_W > OFF_W) ? COORD_W : OFF_W) + 1;

    typedef logic signed [COORD_W-1:0] coord_t;
    typedef logic signed [OFF_W-1:0]   off_t;
    typedef logic signed [SUM_W-1:0]   sum_t;
    typedef logic signed [DEC_W-1:0]   dec_t;

    // item kinds
    localparam logic KIND_START = 1'b0;
    localparam logic KIND_STEP  = 1'b1;

    // span slots of one iteration
    localparam logic [SLOT_W-1:0] SLOT_FIRST = SLOT_W'(0);
    localparam logic [SLOT_W-1:0] SLOT_LAST  = SLOT_W'(SLOTS - 1);

    // midpoint decision constants
    localparam dec_t DEC_INIT    = DEC_W'(3);
    localparam dec_t DEC_INC_IN  = DEC_W'(6);
    localparam dec_t DEC_INC_OUT = DEC_W'(10);
    localparam int   DEC_SHIFT   = 2;

    // saturation bounds
    localparam coord_t COORD_HI = coord_t'((1 << (COORD_W - 1)) - 1);
    localparam coord_t COORD_LO = coord_t'(-(1 << (COORD_W - 1)));
    localparam sum_t   SUM_HI   = sum_t'((1 << (COORD_W - 1)) - 1);
    localparam sum_t   SUM_LO   = sum_t'(-(1 << (COORD_W - 1)));

    typedef enum logic {
        ST_IDLE,
        ST_EMIT
    } seq_state_t;

    // one span request from the sequencer to the output stage
    typedef struct packed {
        logic emit;
        logic last;
        logic done;
        off_t left_off;
        off_t right_off;
        off_t row_off;
    } span_req_t;

    // clamp a widened sum to the signed coordinate range
    function automatic coord_t sat_coord(input sum_t v);
        coord_t res;
        if (v > SUM_HI) begin
            res = COORD_HI;
        end else if (v < SUM_LO) begin
            res = COORD_LO;
        end else begin
            res = coord_t'(v[COORD_W-1:0]);
        end
        return res;
    endfunction

endpackage

/* src/mcr_coord_unit.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mcr_coord_unit
// Shared span coordinate unit: adds offsets to the centre and saturates.
// ----------------------------------------------------------------------------
module mcr_coord_unit
    import mcr_pkg::*;
(
    input  coord_t org_x,
    input  coord_t org_y,
    input  off_t   left_off,
    input  off_t   right_off,
    input  off_t   row_off,
    output coord_t left,
    output coord_t right,
    output coord_t row
);

    sum_t left_sum;
    sum_t right_sum;
    sum_t row_sum;

    // widen, add, clamp
    assign left_sum  = sum_t'(org_x) + sum_t'(left_off);
    assign right_sum = sum_t'(org_x) + sum_t'(right_off);
    assign row_sum   = sum_t'(org_y) + sum_t'(row_off);

    assign left  = sat_coord(left_sum);
    assign right = sat_coord(right_sum);
    assign row   = sat_coord(row_sum);

endmodule

/* src/mcr_seq.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mcr_seq
// Shape state and slot sequencer: walks the span slots of one iteration,
// then applies the midpoint decision update.
// ----------------------------------------------------------------------------
module mcr_seq
    import mcr_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                item_valid,
    output logic                item_stall,
    input  logic                kind,
    input  coord_t              center_x,
    input  coord_t              center_y,
    input  logic [RAD_W-1:0]    radius,
    input  logic [COLOUR_W-1:0] paint,
    input  logic [MODE_W-1:0]   mode,
    input  logic                slot_go,
    output span_req_t           req,
    output coord_t              org_x,
    output coord_t              org_y,
    output logic [COLOUR_W-1:0] colour
);

    seq_state_t                state_reg, state_next;
    logic [SLOT_W-1:0]         slot_reg, slot_next;
    logic                      busy_reg, busy_next;
    coord_t                    orig_x_reg, orig_x_next;
    coord_t                    orig_y_reg, orig_y_next;
    logic [LOOP_W-1:0]         step_x_reg, step_x_next;
    logic signed [LOOP_W-1:0]  step_y_reg, step_y_next;
    dec_t                      decision_reg, decision_next;
    logic [COLOUR_W-1:0]       colour_reg, colour_next;
    logic [MODE_W-1:0]         mode_reg, mode_next;

    off_t                      x_s;
    off_t                      y_s;
    off_t                      y_adv;
    off_t                      xn;
    off_t                      yn;
    logic                      filled;
    logic                      row_neg;
    logic                      dec_neg;
    logic                      adv;
    logic                      fin;
    logic [SLOTS-1:0]          mask;
    logic                      later;
    dec_t                      x_d;
    dec_t                      diff_d;
    dec_t                      delta;
    logic                      accept;
    logic                      slot_done;

    // loop values and the outcome of this iteration
    always_comb
    begin
        x_s     = off_t'({1'b0, step_x_reg});
        y_s     = off_t'(step_y_reg);
        filled  = mode_reg[1];
        row_neg = mode_reg[0];
        dec_neg = decision_reg[DEC_W-1];
        adv     = !filled || (x_s < y_s);
        y_adv   = dec_neg ? y_s : y_s - off_t'(1);
        xn      = adv ? x_s + off_t'(1) : x_s;
        yn      = adv ? y_adv : y_s;
        fin     = filled ? (xn >= yn) : (xn > yn);
        if (filled) begin
            mask = {1'b0, (xn == yn), (adv && !dec_neg), adv};
        end else begin
            mask = {SLOTS{1'b1}};
        end
        x_d    = dec_t'(x_s);
        diff_d = dec_t'(x_s) - dec_t'(y_s);
        delta  = dec_neg ? (x_d <<< DEC_SHIFT) + DEC_INC_IN
                         : (diff_d <<< DEC_SHIFT) + DEC_INC_OUT;
    end

    // offsets and flags of the current slot
    always_comb
    begin
        req.left_off  = '0;
        req.right_off = '0;
        req.row_off   = '0;
        case (slot_reg)
            2'd0:
            begin
                if (filled) begin
                    req.right_off = y_s;
                    req.row_off   = -x_s;
                end else begin
                    req.left_off  = x_s;
                    req.right_off = x_s;
                    req.row_off   = row_neg ? -y_s : y_s;
                end
            end
            2'd1:
            begin
                if (filled) begin
                    req.right_off = x_s;
                    req.row_off   = -y_s;
                end else begin
                    req.left_off  = -x_s;
                    req.right_off = -x_s;
                    req.row_off   = row_neg ? -y_s : y_s;
                end
            end
            2'd2:
            begin
                if (filled) begin
                    req.right_off = yn;
                    req.row_off   = -xn;
                end else begin
                    req.left_off  = y_s;
                    req.right_off = y_s;
                    req.row_off   = row_neg ? -x_s : x_s;
                end
            end
            default:
            begin
                if (!filled) begin
                    req.left_off  = -y_s;
                    req.right_off = -y_s;
                    req.row_off   = row_neg ? -x_s : x_s;
                end
            end
        endcase

        // last enabled slot of this iteration
        case (slot_reg)
            2'd0:    later = |mask[3:1];
            2'd1:    later = |mask[3:2];
            2'd2:    later = mask[3];
            default: later = 1'b0;
        endcase
        req.emit = (state_reg == ST_EMIT) && mask[slot_reg];
        req.last = !later;
        req.done = !later && fin;
    end

    assign item_stall = (state_reg != ST_IDLE);
    assign accept     = item_valid && !item_stall;
    assign slot_done  = (state_reg == ST_EMIT) && (!mask[slot_reg] || slot_go);

    // next state and shape registers
    always_comb
    begin
        state_next    = state_reg;
        slot_next     = slot_reg;
        busy_next     = busy_reg;
        orig_x_next   = orig_x_reg;
        orig_y_next   = orig_y_reg;
        step_x_next   = step_x_reg;
        step_y_next   = step_y_reg;
        decision_next = decision_reg;
        colour_next   = colour_reg;
        mode_next     = mode_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (accept) begin
                    if (kind == KIND_START) begin
                        orig_x_next   = center_x;
                        orig_y_next   = center_y;
                        step_x_next   = '0;
                        step_y_next   = LOOP_W'(radius);
                        decision_next = DEC_INIT - dec_t'({radius, 1'b0});
                        colour_next   = paint;
                        mode_next     = mode;
                        busy_next     = 1'b1;
                    end else if (busy_reg) begin
                        state_next = ST_EMIT;
                        slot_next  = SLOT_FIRST;
                    end
                end
            end
            ST_EMIT:
            begin
                if (slot_done) begin
                    slot_next = slot_reg + SLOT_W'(1);
                    if (slot_reg == SLOT_LAST) begin
                        if (adv) begin
                            step_x_next   = xn[LOOP_W-1:0];
                            step_y_next   = yn[LOOP_W-1:0];
                            decision_next = decision_reg + delta;
                        end
                        busy_next  = !fin;
                        state_next = ST_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // state register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    // shape registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            slot_reg     <= '0;
            busy_reg     <= 1'b0;
            orig_x_reg   <= '0;
            orig_y_reg   <= '0;
            step_x_reg   <= '0;
            step_y_reg   <= '0;
            decision_reg <= '0;
            colour_reg   <= '0;
            mode_reg     <= '0;
        end else begin
            slot_reg     <= slot_next;
            busy_reg     <= busy_next;
            orig_x_reg   <= orig_x_next;
            orig_y_reg   <= orig_y_next;
            step_x_reg   <= step_x_next;
            step_y_reg   <= step_y_next;
            decision_reg <= decision_next;
            colour_reg   <= colour_next;
            mode_reg     <= mode_next;
        end
    end

    assign org_x  = orig_x_reg;
    assign org_y  = orig_y_reg;
    assign colour = colour_reg;

`ifndef SYNTH
    // an active shape never has x beyond y
    assert property (@(posedge clk) disable iff (!rst_n)
        busy_reg |-> (off_t'({1'b0, step_x_reg}) <= off_t'(step_y_reg)))
        else $error("loop x passed loop y while busy");

    // the finishing iteration leaves the block idle
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_EMIT && slot_reg == SLOT_LAST && slot_done && fin)
        |=> (!busy_reg && state_reg == ST_IDLE))
        else $error("shape still busy after finishing iteration");

    // a waiting slot holds its place
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_EMIT && !slot_done) |=> $stable(slot_reg))
        else $error("slot moved while its span was waiting");

    // done only on the final span of a step
    assert property (@(posedge clk) disable iff (!rst_n)
        (req.emit && req.done) |-> req.last)
        else $error("done flagged on a span that is not last");
`endif

endmodule

/* src/midpoint_circle_rasterizer_unit.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// midpoint_circle_rasterizer_unit
// Midpoint circle generator: start items load a shape, step items emit spans.
// ----------------------------------------------------------------------------
// Start item: no span; the block stays idle and is ready again the next cycle.
// Step item: the sequencer walks four span slots through the shared coordinate
// unit at one slot per cycle while the output is not stalled; an enabled slot
// waits while its span is held. The step is registered into the sequencer
// state, each span into the output register; items wait for the last slot.
// Reset (rst_n low, asynchronous) leaves the block idle with no shape loaded.
// ----------------------------------------------------------------------------
module midpoint_circle_rasterizer_unit
    import mcr_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                item_valid,
    output logic                item_stall,
    input  logic                kind,
    input  coord_t              center_x,
    input  coord_t              center_y,
    input  logic [RAD_W-1:0]    radius,
    input  logic [COLOUR_W-1:0] paint,
    input  logic [MODE_W-1:0]   mode,
    output logic                span_valid,
    input  logic                span_stall,
    output coord_t              span_left,
    output coord_t              span_right,
    output coord_t              span_row,
    output logic [COLOUR_W-1:0] pixel_colour,
    output logic                last_of_step,
    output logic                done_res
);

    span_req_t           req;
    coord_t              org_x;
    coord_t              org_y;
    logic [COLOUR_W-1:0] colour;
    coord_t              left;
    coord_t              right;
    coord_t              row;
    logic                slot_go;
    logic                load;

    logic                out_valid_reg, out_valid_next;
    coord_t              left_reg;
    coord_t              right_reg;
    coord_t              row_reg;
    logic [COLOUR_W-1:0] colour_reg;
    logic                last_reg;
    logic                done_reg;

    mcr_seq u_seq (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (item_valid),
        .item_stall (item_stall),
        .kind       (kind),
        .center_x   (center_x),
        .center_y   (center_y),
        .radius     (radius),
        .paint      (paint),
        .mode       (mode),
        .slot_go    (slot_go),
        .req        (req),
        .org_x      (org_x),
        .org_y      (org_y),
        .colour     (colour)
    );

    mcr_coord_unit u_coord (
        .org_x     (org_x),
        .org_y     (org_y),
        .left_off  (req.left_off),
        .right_off (req.right_off),
        .row_off   (req.row_off),
        .left      (left),
        .right     (right),
        .row       (row)
    );

    // output register takes a span when empty or being drained
    assign slot_go = !out_valid_reg || !span_stall;
    assign load    = req.emit && slot_go;

    always_comb
    begin
        if (load) begin
            out_valid_next = 1'b1;
        end else if (span_stall) begin
            out_valid_next = out_valid_reg;
        end else begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            out_valid_reg <= 1'b0;
        end else begin
            out_valid_reg <= out_valid_next;
        end
    end

    // span payload
    always_ff @(posedge clk)
    begin
        if (load) begin
            left_reg   <= left;
            right_reg  <= right;
            row_reg    <= row;
            colour_reg <= colour;
            last_reg   <= req.last;
            done_reg   <= req.done;
        end
    end

    assign span_valid   = out_valid_reg;
    assign span_left    = left_reg;
    assign span_right   = right_reg;
    assign span_row     = row_reg;
    assign pixel_colour = colour_reg;
    assign last_of_step = last_reg;
    assign done_res     = done_reg;

`ifndef SYNTH
    // new items wait while a step is still producing spans
    assert property (@(posedge clk) disable iff (!rst_n)
        req.emit |-> item_stall)
        else $error("span slot active while items are accepted");

    // a span is never loaded over one that is stalled
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && span_stall) |-> !load)
        else $error("output register overwritten while stalled");

    // a step that ends a shape reports done on its final span
    assert property (@(posedge clk) disable iff (!rst_n)
        (span_valid && done_res) |-> last_of_step)
        else $error("done without last on output");
`endif

endmodule

/* sim/tb_top.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the midpoint circle rasterizer. A directed table and
// then random shape sequences (start, a run of steps, some broken or
// abandoned) are driven with random idling on both sides. An in-bench model
// of the midpoint loop predicts the spans but for typed table rows, which carry
// hand-written ones; each span transfer is compared field by field in order.
// ----------------------------------------------------------------------------
module tb_top
    import mcr_pkg::*;
();

    localparam logic [MODE_W-1:0] MODE_UP       = 2'd0;
    localparam logic [MODE_W-1:0] MODE_DOWN     = 2'd1;
    localparam logic [MODE_W-1:0] MODE_FILL     = 2'd2;
    localparam logic [MODE_W-1:0] MODE_FILL_ALT = 2'd3;

    localparam int PLAN_LEN     = 24;
    localparam int RANDOM_ITEMS = 150;
    localparam int QUIET_LIMIT  = 3000;
    localparam int LONG_HOLD    = 400;
    localparam int DRAIN_CYCLES = 30;

    // one span as seen on the output channel
    typedef struct packed {
        coord_t              left;
        coord_t              right;
        coord_t              row;
        logic [COLOUR_W-1:0] colour;
        logic                last;
        logic                done;
    } span_t;

    // one input item, with an optional hand-written expectation
    typedef struct packed {
        logic                kind;
        coord_t              cx;
        coord_t              cy;
        logic [RAD_W-1:0]    rad;
        logic [COLOUR_W-1:0] col;
        logic [MODE_W-1:0]   md;
        bit                  typed;
        int                  exp_n;
        coord_t              el;
        coord_t              er;
        coord_t              erow;
        logic [COLOUR_W-1:0] ecol;
    } stim_t;

    logic                clk;
    logic                rst_n;
    logic                item_valid;
    logic                item_stall;
    logic                kind;
    coord_t              center_x;
    coord_t              center_y;
    logic [RAD_W-1:0]    radius;
    logic [COLOUR_W-1:0] paint;
    logic [MODE_W-1:0]   mode;
    logic                span_valid;
    logic                span_stall;
    coord_t              span_left;
    coord_t              span_right;
    coord_t              span_row;
    logic [COLOUR_W-1:0] pixel_colour;
    logic                last_of_step;
    logic                done_res;

    // shape state of the predictor
    coord_t              org_x;
    coord_t              org_y;
    logic [LOOP_W-1:0]   loop_x;
    logic signed [LOOP_W-1:0] loop_y;
    dec_t                dvar;
    logic [COLOUR_W-1:0] hue;
    logic [MODE_W-1:0]   shape_mode;
    bit                  active;

    span_t spans_due[$];
    span_t fresh[$];
    stim_t plan [PLAN_LEN];
    stim_t row_exp;
    bit    row_typed;
    int    fails;
    int    spans_got;
    int    useful_items;
    int    quiet;

    midpoint_circle_rasterizer_unit u_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_stall   (item_stall),
        .kind         (kind),
        .center_x     (center_x),
        .center_y     (center_y),
        .radius       (radius),
        .paint        (paint),
        .mode         (mode),
        .span_valid   (span_valid),
        .span_stall   (span_stall),
        .span_left    (span_left),
        .span_right   (span_right),
        .span_row     (span_row),
        .pixel_colour (pixel_colour),
        .last_of_step (last_of_step),
        .done_res     (done_res)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // clamp to the signed coordinate range
    function automatic coord_t clamp_coord(input int v);
        coord_t res;
        if (v > int'(COORD_HI))
        begin
            res = COORD_HI;
        end
        else if (v < int'(COORD_LO))
        begin
            res = COORD_LO;
        end
        else
        begin
            res = coord_t'(v);
        end
        return res;
    endfunction

    function automatic void add_span(input int l, input int r, input int row);
        span_t s;
        s = '{clamp_coord(l), clamp_coord(r), clamp_coord(row), hue, 1'b0, 1'b0};
        fresh.push_back(s);
    endfunction

    // one midpoint iteration: decision update, y may step in, x steps out
    function automatic void bump_decision(inout int x, inout int y, inout int d);
        if (d < 0)
        begin
            d = d + (x <<< DEC_SHIFT) + int'(DEC_INC_IN);
        end
        else
        begin
            d = d + ((x - y) <<< DEC_SHIFT) + int'(DEC_INC_OUT);
            y = y - 1;
        end
        x = x + 1;
    endfunction

    // spans caused by one accepted item, left in fresh
    function automatic void plot_item(input logic k, input coord_t cx, input coord_t cy,
                                      input logic [RAD_W-1:0] r,
                                      input logic [COLOUR_W-1:0] col,
                                      input logic [MODE_W-1:0] m);
        int x;
        int y;
        int d;
        int ox;
        int oy;
        int sgn;
        bit fin;
        fresh.delete();
        if (k == KIND_START)
        begin
            org_x      = cx;
            org_y      = cy;
            hue        = col;
            shape_mode = m;
            loop_x     = '0;
            loop_y     = LOOP_W'(r);
            dvar       = dec_t'(int'(DEC_INIT) - 2 * int'(r));
            active     = 1'b1;
            return;
        end
        if (!active)
        begin
            return;
        end
        x   = int'(loop_x);
        y   = int'(loop_y);
        d   = int'(dvar);
        ox  = int'(org_x);
        oy  = int'(org_y);
        fin = 1'b0;
        if (shape_mode == MODE_UP || shape_mode == MODE_DOWN)
        begin
            // four octant pixels, mirrored about the centre column; the mode sets the row sign
            sgn = (shape_mode == MODE_UP) ? 1 : -1;
            add_span(ox + x, ox + x, oy + sgn * y);
            add_span(ox - x, ox - x, oy + sgn * y);
            add_span(ox + y, ox + y, oy + sgn * x);
            add_span(ox - y, ox - y, oy + sgn * x);
            bump_decision(x, y, d);
            fin = (x > y);
        end
        else
        begin
            // filled quarter, mode three included
            if (x < y)
            begin
                add_span(ox, ox + y, oy - x);
                if (d >= 0)
                begin
                    add_span(ox, ox + x, oy - y);
                end
                bump_decision(x, y, d);
            end
            if (x >= y)
            begin
                if (x == y)
                begin
                    add_span(ox, ox + y, oy - x);
                end
                fin = 1'b1;
            end
        end
        loop_x = LOOP_W'(x);
        loop_y = LOOP_W'(y);
        dvar   = dec_t'(d);
        if (fin)
        begin
            active = 1'b0;
        end
        if (fresh.size() > 0)
        begin
            fresh[fresh.size() - 1].last = 1'b1;
            fresh[fresh.size() - 1].done = fin;
        end
    endfunction

    function automatic void check_field(input string name, input int want, input int got);
        if (want != got)
        begin
            $error("%s: expected %0d, got %0d", name, want, got);
            fails++;
        end
    endfunction

    // span check first, then prediction of the item taken in the same cycle
    always @(posedge clk)
    begin : span_check
        span_t want;
        if (rst_n && span_valid && !span_stall)
        begin
            spans_got++;
            if (spans_due.size() == 0)
            begin
                $error("span with nothing expected: left %0d right %0d row %0d",
                       span_left, span_right, span_row);
                fails++;
            end
            else
            begin
                want = spans_due.pop_front();
                check_field("span_left", want.left, span_left);
                check_field("span_right", want.right, span_right);
                check_field("span_row", want.row, span_row);
                check_field("pixel_colour", want.colour, pixel_colour);
                check_field("last_of_step", want.last, last_of_step);
                check_field("done_res", want.done, done_res);
            end
        end
        if (rst_n && item_valid && !item_stall)
        begin
            if (kind == KIND_START || active)
            begin
                useful_items++;
            end
            plot_item(kind, center_x, center_y, radius, paint, mode);
            if (row_typed)
            begin
                for (int i = 0; i < row_exp.exp_n; i++)
                begin
                    spans_due.push_back('{row_exp.el, row_exp.er, row_exp.erow, row_exp.ecol,
                                          i == row_exp.exp_n - 1, i == row_exp.exp_n - 1});
                end
            end
            else
            begin
                foreach (fresh[i])
                begin
                    spans_due.push_back(fresh[i]);
                end
            end
        end
    end

    // watchdog on cycles with no transfer on either channel
    always @(posedge clk)
    begin
        if (!rst_n || (item_valid && !item_stall) || (span_valid && !span_stall))
        begin
            quiet <= 0;
        end
        else
        begin
            quiet <= quiet + 1;
        end
        if (quiet >= QUIET_LIMIT)
        begin
            $display("tb_top: FAIL");
            $finish;
        end
    end

    // mostly no gap, some short, a few long
    function automatic int pick_gap();
        int r;
        int g;
        r = $urandom_range(0, 99);
        if (r < 55)
        begin
            g = 0;
        end
        else if (r < 90)
        begin
            g = $urandom_range(1, 3);
        end
        else
        begin
            g = $urandom_range(4, 40);
        end
        return g;
    endfunction

    // coordinates, often close to the edges to exercise saturation
    function automatic coord_t pick_coord();
        coord_t c;
        case ($urandom_range(0, 3))
            0: c = COORD_HI - coord_t'($urandom_range(0, 20));
            1: c = COORD_LO + coord_t'($urandom_range(0, 20));
            default: c = coord_t'($urandom);
        endcase
        return c;
    endfunction

    function automatic stim_t rand_item(input logic k);
        stim_t s;
        s      = '0;
        s.kind = k;
        s.cx   = pick_coord();
        s.cy   = pick_coord();
        s.rad  = RAD_W'($urandom);
        s.col  = COLOUR_W'($urandom);
        s.md   = MODE_W'($urandom_range(0, 3));
        return s;
    endfunction

    // hold valid low for gap cycles, then offer the item until its transfer
    task automatic offer(input stim_t s, input int gap);
        repeat (gap)
        begin
            @(negedge clk);
            item_valid <= 1'b0;
        end
        @(negedge clk);
        item_valid <= 1'b1;
        kind       <= s.kind;
        center_x   <= s.cx;
        center_y   <= s.cy;
        radius     <= s.rad;
        paint      <= s.col;
        mode       <= s.md;
        row_typed  = s.typed;
        row_exp    = s;
        do
        begin
            @(posedge clk);
        end
        while (!(item_valid && !item_stall));
    endtask

    // receiver: random stall bursts, free-running stretches, one long hold-off
    initial
    begin : span_sink
        bit held_long;
        int n;
        held_long = 1'b0;
        wait (rst_n === 1'b1);
        forever
        begin
            if (!held_long && spans_got >= 40)
            begin
                held_long = 1'b1;
                repeat (LONG_HOLD)
                begin
                    @(negedge clk);
                    span_stall <= 1'b1;
                end
            end
            n = pick_gap();
            repeat (n)
            begin
                @(negedge clk);
                span_stall <= 1'b1;
            end
            n = ($urandom_range(0, 5) == 0) ? $urandom_range(20, 60) : $urandom_range(1, 12);
            repeat (n)
            begin
                @(negedge clk);
                span_stall <= 1'b0;
            end
        end
    end

    initial
    begin : stimulus
        stim_t s;
        int    rad;
        int    nsteps;
        bit    burst;
        fails        = 0;
        spans_got    = 0;
        useful_items = 0;
        row_typed    = 1'b0;
        row_exp      = '0;
        active       = 1'b0;
        org_x        = '0;
        org_y        = '0;
        loop_x       = '0;
        loop_y       = '0;
        dvar         = '0;
        hue          = '0;
        shape_mode   = '0;
        rst_n        = 1'b0;
        item_valid   = 1'b0;
        kind         = KIND_START;
        center_x     = '0;
        center_y     = '0;
        radius       = '0;
        paint        = '0;
        mode         = MODE_UP;
        span_stall   = 1'b0;

        // kind, centre, radius, colour, mode, typed, count, left, right, row, colour
        plan = '{
            '{KIND_STEP,  12'sd0, 12'sd0, 10'd0, 16'h0000, MODE_UP, 1'b1, 0,
              12'sd0, 12'sd0, 12'sd0, 16'h0000},
            '{KIND_START, 12'sd5, -12'sd7, 10'd0, 16'hFFFF, MODE_UP, 1'b1, 0,
              12'sd0, 12'sd0, 12'sd0, 16'h0000},
            '{KIND_STEP,  12'sd0, 12'sd0, 10'd0, 16'h0000, MODE_UP, 1'b1, 4,
              12'sd5, 12'sd5, -12'sd7, 16'hFFFF},
            '{KIND_STEP,  12'sd0, 12'sd0, 10'd0, 16'h0000, MODE_UP, 1'b1, 0,
              12'sd0, 12'sd0, 12'sd0, 16'h0000},
            '{KIND_START, COORD_HI, COORD_LO, 10'd0, 16'h0000, MODE_DOWN, 1'b1, 0,
              12'sd0, 12'sd0, 12'sd0, 16'h0000},
            '{KIND_STEP,  12'sd0, 12'sd0, 10'd0, 16'h0000, MODE_UP, 1'b1, 4,
              COORD_HI, COORD_HI, COORD_LO, 16'h0000},
            '{KIND_START, COORD_LO, COORD_HI, 10'd0, 16'hA5A5, MODE_FILL, 1'b1, 0,
              12'sd0, 12'sd0, 12'sd0, 16'h0000},
            '{KIND_STEP,  12'sd0, 12'sd0, 10'd0, 16'h0000, MODE_UP, 1'b1, 1,
              COORD_LO, COORD_LO, COORD_HI, 16'hA5A5},
            // largest radius at the corners, saturating
            '{KIND_START, COORD_HI, COORD_HI, 10'd1023, 16'h5A5A, MODE_UP, 1'b0, 0,
              12'sd0, 12'sd0, 12'sd0, 16'h0000},
            '{KIND_STEP,  12'sd0, 12'sd0, 10'd0, 16'h0000, MODE_UP, 1'b0, 0,
              12'sd0, 12'sd0, 12'sd0, 16'h0000},
            '{KIND_STEP,  12'sd0, 12'sd0, 10'd0, 16'h0000, MODE_UP, 1'b0, 0,
              12'sd0, 12'sd0, 12'sd0, 16'h0000},
            // restart while a shape is in progress
            '{KIND_START, COORD_LO, COORD_LO, 10'd1023, 16'h1234, MODE_DOWN, 1'b0, 0,
              12'sd0, 12'sd0, 12'sd0, 16'h0000},
            '{KIND_STEP,  12'sd0, 12'sd0, 10'd0, 16'h0000, MODE_UP, 1'b0, 0,
              12'sd0, 12'sd0, 12'sd0, 16'h0000},
            '{KIND_STEP,  12'sd0, 12'sd0, 10'd0, 16'h0000, MODE_UP, 1'b0, 0,
              12'sd0, 12'sd0, 12'sd0, 16'h0000},
            // filled quarter run to the end, then one idle step
            '{KIND_START, 12'sd0, 12'sd0, 10'd5, 16'hF800, MODE_FILL, 1'b0, 0,
              12'sd0, 12'sd0, 12'sd0, 16'h0000},
            '{KIND_STEP,  12'sd0, 12'sd0, 10'd0, 16'h0000, MODE_UP, 1'b0, 0,
              12'sd0, 12'sd0, 12'sd0, 16'h0000},
            '{KIND_STEP,  12'sd0, 12'sd0, 10'd0, 16'h0000, MODE_UP, 1'b0, 0,
              12'sd0, 12'sd0, 12'sd0, 16'h0000},
            '{KIND_STEP,  12'sd0, 12'sd0, 10'd0, 16'h0000, MODE_UP, 1'b0, 0,
              12'sd0, 12'sd0, 12'sd0, 16'h0000},
            '{KIND_STEP,  12'sd0, 12'sd0, 10'd0, 16'h0000, MODE_UP, 1'b0, 0,
              12'sd0, 12'sd0, 12'sd0, 16'h0000},
            '{KIND_STEP,  12'sd0, 12'sd0, 10'd0, 16'h0000, MODE_UP, 1'b0, 0,
              12'sd0, 12'sd0, 12'sd0, 16'h0000},
            // mode three acts as the filled quarter
            '{KIND_START, 12'sd10, 12'sd10, 10'd3, 16'h07E0, MODE_FILL_ALT, 1'b0, 0,
              12'sd0, 12'sd0, 12'sd0, 16'h0000},
            '{KIND_STEP,  12'sd0, 12'sd0, 10'd0, 16'h0000, MODE_UP, 1'b0, 0,
              12'sd0, 12'sd0, 12'sd0, 16'h0000},
            '{KIND_STEP,  12'sd0, 12'sd0, 10'd0, 16'h0000, MODE_UP, 1'b0, 0,
              12'sd0, 12'sd0, 12'sd0, 16'h0000},
            '{KIND_STEP,  12'sd0, 12'sd0, 10'd0, 16'h0000, MODE_UP, 1'b0, 0,
              12'sd0, 12'sd0, 12'sd0, 16'h0000}
        };

        // reset
        repeat (10) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // directed table
        foreach (plan[i])
        begin
            offer(plan[i], pick_gap());
        end

        // random shape sequences
        useful_items = 0;
        while (useful_items < RANDOM_ITEMS)
        begin
            burst = ($urandom_range(0, 4) == 0);
            // stray steps before the start: idle or continuing the last shape
            if ($urandom_range(0, 6) == 0)
            begin
                repeat ($urandom_range(1, 3))
                begin
                    offer(rand_item(KIND_STEP), burst ? 0 : pick_gap());
                end
            end
            s   = rand_item(KIND_START);
            rad = ($urandom_range(0, 4) == 0) ? $urandom_range(0, 1023) : $urandom_range(0, 24);
            s.rad = RAD_W'(rad);
            if (rad > 24)
            begin
                nsteps = $urandom_range(1, 6);
            end
            else if ($urandom_range(0, 1) == 0)
            begin
                nsteps = rad + 2;
            end
            else
            begin
                nsteps = $urandom_range(1, rad + 2);
            end
            offer(s, burst ? 0 : pick_gap());
            repeat (nsteps)
            begin
                offer(rand_item(KIND_STEP), burst ? 0 : pick_gap());
            end
        end
        @(negedge clk);
        item_valid <= 1'b0;

        // drain
        while (spans_due.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (fails == 0)
        begin
            $display("tb_top: PASS");
        end
        else
        begin
            $display("tb_top: FAIL");
        end
        $finish;
    end

endmodule
